### rtl/pod_pkg.sv
// Shared constants, types and codes for the priority-ordered deque.
`timescale 1ns / 1ps
package pod_pkg;

  localparam int CAPACITY = 16;
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    KIND_INS_REAR  = 3'd0,
    KIND_INS_FRONT = 3'd1,
    KIND_REM_FRONT = 3'd2,
    KIND_REM_REAR  = 3'd3,
    KIND_SEARCH    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [15:0]        prio;
  } job_t;

endpackage

### rtl/pod_req_if.sv
// Request and response channel interfaces of the priority-ordered deque.
`timescale 1ns / 1ps
interface pod_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] job_data;
  logic [15:0]        job_prio;

  modport source (output valid, kind, job_data, job_prio, input ready);
  modport sink (input valid, kind, job_data, job_prio, output ready);
endinterface

interface pod_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_data;
  logic [15:0]        out_priority;
  logic [4:0]         position;
  logic [4:0]         occupancy;

  modport source (output valid, status, out_data, out_priority, position, occupancy,
                  input ready);
  modport sink (input valid, status, out_data, out_priority, position, occupancy,
                output ready);
endinterface

### rtl/priority_ordered_deque_top.sv
// Top level of the priority-ordered deque: circular job memory and its sequencer.
// Full, empty and ignored requests go straight to the response without reading the job memory;
// removes read one slot, searches and inserts walk up to the occupancy, and inserts shift
// entries as they walk and then write the new job. One request is in flight at a time; a new
// request is taken only after the last one has loaded its response. A finished response waits in the
// output register while the next request is taken. Reset empties the queue; no clearing pass.
`timescale 1ns / 1ps
module priority_ordered_deque_top (
  input logic clk,
  input logic rst,
  pod_req_if.sink   req,
  pod_rsp_if.source rsp
);
  import pod_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_EVAL  = 5'b00100,
    S_WNEW  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  job_t   mem [CAPACITY];
  job_t   rdata;

  logic [2:0]     kind;
  job_t           job;
  logic [CW-1:0]  cnt;
  logic [AW-1:0]  head;
  logic [AW-1:0]  j;
  logic [AW:0]    wpos;
  status_t        res_status;
  job_t           res_job;
  logic [CW-1:0]  res_pos;

  logic           we;
  logic [AW-1:0]  waddr;
  job_t           wdata;
  logic [AW-1:0]  raddr;
  logic           move;
  logic           is_ins;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + l;
    if (s >= (AW+1)'(CAPACITY)) s = s - (AW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  assign req.ready = (state == S_IDLE);
  assign is_ins = (kind == KIND_INS_REAR) || (kind == KIND_INS_FRONT);
  assign raddr = phys(head, {1'b0, j});
  assign move = (kind == KIND_INS_REAR) ? (rdata.prio > job.prio) : (rdata.prio >= job.prio);

  always_comb begin
    we = 1'b0;
    waddr = phys(head, wpos);
    wdata = job;
    if (state == S_EVAL && is_ins && move) begin
      we = 1'b1;
      waddr = phys(head, {1'b0, j} + (AW+1)'(1));
      wdata = rdata;
    end else if (state == S_WNEW) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      head <= '0;
      rsp.valid <= 1'b0;
    end else begin
      // drop the response once taken, unless a new one loads this cycle
      if (rsp.valid && rsp.ready && state != S_DONE) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind <= req.kind;
            job.data <= req.job_data;
            job.prio <= req.job_prio;
            res_status <= ST_OK;
            res_job <= '0;
            res_pos <= '0;
            state <= S_ISSUE;
            case (req.kind)
              KIND_INS_REAR, KIND_INS_FRONT: begin
                if (cnt == CW'(CAPACITY)) begin
                  res_status <= ST_FULL;
                  state <= S_DONE;
                end else if (cnt == '0) begin
                  wpos <= '0;
                  state <= S_WNEW;
                end else begin
                  j <= AW'(cnt - CW'(1));
                end
              end
              KIND_REM_FRONT, KIND_SEARCH: begin
                j <= '0;
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state <= S_DONE;
                end
              end
              KIND_REM_REAR: begin
                j <= AW'(cnt - CW'(1));
                if (cnt == '0) begin
                  res_status <= ST_EMPTY;
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ISSUE: state <= S_EVAL;
        S_EVAL: begin
          state <= S_DONE;
          case (kind)
            KIND_INS_REAR, KIND_INS_FRONT: begin
              if (move && j != '0) begin
                j <= j - AW'(1);
                state <= S_ISSUE;
              end else begin
                wpos <= move ? '0 : ({1'b0, j} + (AW+1)'(1));
                state <= S_WNEW;
              end
            end
            KIND_REM_FRONT: begin
              res_job <= rdata;
              head <= phys(head, (AW+1)'(1));
              cnt <= cnt - CW'(1);
            end
            KIND_REM_REAR: begin
              res_job <= rdata;
              cnt <= cnt - CW'(1);
            end
            KIND_SEARCH: begin
              if (rdata.data == job.data) begin
                res_pos <= CW'(j) + CW'(1);
              end else if (CW'(j) == cnt - CW'(1)) begin
                res_status <= ST_NOTFOUND;
              end else begin
                j <= j + AW'(1);
                state <= S_ISSUE;
              end
            end
            default: ;
          endcase
        end
        S_WNEW: begin
          cnt <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.status <= res_status;
            rsp.out_data <= res_job.data;
            rsp.out_priority <= res_job.prio;
            rsp.position <= 5'(res_pos);
            rsp.occupancy <= 5'(cnt);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
